@@ hw/rtl/at_response_ipd_framer_assert.svh @@
// assertion macros for the ipd framer
// used by the top level only, no other dependencies
`ifndef AT_RESPONSE_IPD_FRAMER_ASSERT_SVH
`define AT_RESPONSE_IPD_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define IPDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IPDF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define IPDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPDF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ hw/rtl/ipdf_pkg.sv @@
// shared types and constants of the ipd framer
// no dependencies
`timescale 1ns / 1ps

package ipdf_pkg;

    typedef enum logic [1:0] {
        FN_BYTE    = 2'd0,
        FN_TICK    = 2'd1,
        FN_RELEASE = 2'd2,
        FN_RESTART = 2'd3
    } t_func;

    localparam int LEFT_W = 16;
    typedef logic [LEFT_W-1:0] t_left;
    typedef logic [3:0]        t_phase;

    // header letters, then separator and channel, then length digits, then payload
    localparam t_phase PH_IDLE    = 4'd0;
    localparam t_phase PH_SEP     = 4'd4;
    localparam t_phase PH_DIGITS  = 4'd7;
    localparam t_phase PH_PAYLOAD = 4'd8;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] HDR_CHAR [4] = '{8'h2B, 8'h49, 8'h50, 8'h44};

    localparam logic [19:0] LEFT_MAX = 20'd65535;

    typedef struct packed {
        t_phase phase;
        t_left  left;
        logic   close_req;
    } t_scan;

endpackage

@@ hw/rtl/ipdf_hdr_scan.sv @@
// "+IPD,c,len:" header recognizer and payload length countdown
// depends on ipdf_pkg
`timescale 1ns / 1ps

module ipdf_hdr_scan (
    input  ipdf_pkg::t_phase i_phase,
    input  ipdf_pkg::t_left  i_left,
    input  logic [7:0]       i_byte,
    output ipdf_pkg::t_scan  o_scan
);

    logic [19:0]      mul10;
    ipdf_pkg::t_left  left_dec;
    logic             is_digit;

    assign is_digit = (i_byte >= ipdf_pkg::CH_ZERO) && (i_byte <= ipdf_pkg::CH_NINE);
    assign mul10    = ({4'b0, i_left} << 3) + ({4'b0, i_left} << 1)
                    + {12'b0, i_byte - ipdf_pkg::CH_ZERO};
    assign left_dec = (i_left != '0) ? i_left - 1'b1 : '0;

    always_comb begin
        o_scan.phase     = i_phase;
        o_scan.left      = i_left;
        o_scan.close_req = 1'b0;
        if (i_phase == ipdf_pkg::PH_PAYLOAD) begin
            if (left_dec == '0) begin
                o_scan.close_req = 1'b1;
                o_scan.phase     = ipdf_pkg::PH_IDLE;
                o_scan.left      = '0;
            end else begin
                o_scan.left = left_dec;
            end
        end else if (i_phase < ipdf_pkg::PH_SEP
                     && i_byte == ipdf_pkg::HDR_CHAR[i_phase[1:0]]) begin
            o_scan.phase = i_phase + 1'b1;
        end else if (i_phase >= ipdf_pkg::PH_SEP && i_phase < ipdf_pkg::PH_DIGITS) begin
            o_scan.phase = i_phase + 1'b1;
        end else if (i_phase == ipdf_pkg::PH_DIGITS && i_byte != ipdf_pkg::CH_COLON) begin
            if (is_digit) begin
                o_scan.left = (mul10 > ipdf_pkg::LEFT_MAX) ? '1 : mul10[15:0];
            end else begin
                o_scan.phase = ipdf_pkg::PH_IDLE;
                o_scan.left  = '0;
            end
        end else if (i_phase == ipdf_pkg::PH_DIGITS && i_left != '0) begin
            o_scan.phase = ipdf_pkg::PH_PAYLOAD;
        end else if (i_phase != ipdf_pkg::PH_IDLE && i_phase < ipdf_pkg::PH_SEP) begin
            o_scan.phase = ipdf_pkg::PH_IDLE;
            o_scan.left  = '0;
        end
    end

endmodule

@@ hw/rtl/at_response_ipd_framer.sv @@
// ipd message framer top level: input register, state update, result register
// depends on ipdf_pkg, ipdf_hdr_scan and at_response_ipd_framer_assert.svh
`timescale 1ns / 1ps
`include "at_response_ipd_framer_assert.svh"

// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   a received byte, a time tick, a release of the oldest message or a restart.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   command: the byte store request (slot, offset, data), the close and
//   overflow flags, and the pending count, read slot and halt flag after it.
//   i_cfg_we writes idle_ticks from i_cfg_wdata; write it only while idle.
// Pipeline: a command taken is captured in the input register, processed by
//   the state update logic into the result register and shown on the output
//   ports from then on.
// Throughput: one command per cycle unless stalled; the framer state is updated
//   by a single level of compare and multiply-by-ten-add logic between the registers.
// Reset (i_rst_n low, synchronous): both pipeline registers empty, ring and
//   header state cleared, idle_ticks back to 10.
// Stall: while the result register is held, the input register keeps its
//   command and o_in_stall rises only once it is occupied too.
module at_response_ipd_framer #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [7:0]                     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_store_valid,
    output logic [$clog2(SLOTS)-1:0]       o_store_slot,
    output logic [$clog2(SLOT_BYTES)-1:0]  o_store_offset,
    output logic [7:0]                     o_store_data,
    output logic                           o_message_closed,
    output logic [$clog2(SLOTS+1)-1:0]     o_pending_count,
    output logic [$clog2(SLOTS)-1:0]       o_read_slot,
    output logic                           o_overflow_error,
    output logic                           o_halted
);

    localparam int SW = $clog2(SLOTS);
    localparam int OW = $clog2(SLOT_BYTES);
    localparam int FW = $clog2(SLOT_BYTES + 1);
    localparam int PW = $clog2(SLOTS + 1);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // pipeline control
    logic               r_iv, r_ov;
    logic               in_xfer, adv;
    ipdf_pkg::t_func    r_func;
    logic [7:0]         r_byte;

    // framer state
    logic [7:0]         r_idle_ticks;
    logic               r_halt, n_halt;
    logic [SW-1:0]      r_ws, n_ws;
    logic [SW-1:0]      r_rd, n_rd;
    logic [PW-1:0]      r_pend, n_pend;
    logic               r_sw, n_sw;
    logic [FW-1:0]      r_fl, n_fl;
    ipdf_pkg::t_phase   r_phase, n_phase;
    ipdf_pkg::t_left    r_left, n_left;
    logic [7:0]         r_idle, n_idle;
    logic               r_seen, n_seen;

    // result register
    logic               r_o_sv, n_o_sv;
    logic [SW-1:0]      r_o_slot, n_o_slot;
    logic [OW-1:0]      r_o_off, n_o_off;
    logic [7:0]         r_o_data, n_o_data;
    logic               r_o_closed, n_o_closed;
    logic               r_o_ovf, n_o_ovf;
    logic [PW-1:0]      r_o_pend;
    logic [SW-1:0]      r_o_rd;
    logic               r_o_halt;

    logic [SW-1:0]      b_ws;
    logic [FW-1:0]      b_fl, b_fl_inc;
    logic [7:0]         idle_inc;
    ipdf_pkg::t_scan    scan;

    assign adv        = r_iv && (!r_ov || !i_out_stall);
    assign o_in_stall = r_iv && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;

    ipdf_hdr_scan u_scan (
        .i_phase (r_phase),
        .i_left  (r_left),
        .i_byte  (r_byte),
        .o_scan  (scan)
    );

    assign b_ws     = r_sw ? next_slot(r_ws) : r_ws;
    assign b_fl     = r_sw ? '0 : r_fl;
    assign b_fl_inc = b_fl + 1'b1;
    assign idle_inc = r_idle + 1'b1;

    always_comb begin
        n_halt     = r_halt;
        n_ws       = r_ws;
        n_rd       = r_rd;
        n_pend     = r_pend;
        n_sw       = r_sw;
        n_fl       = r_fl;
        n_phase    = r_phase;
        n_left     = r_left;
        n_idle     = r_idle;
        n_seen     = r_seen;
        n_o_sv     = 1'b0;
        n_o_slot   = '0;
        n_o_off    = '0;
        n_o_data   = '0;
        n_o_closed = 1'b0;
        n_o_ovf    = 1'b0;
        if (adv) begin
            case (r_func)
                ipdf_pkg::FN_BYTE: begin
                    if (!r_halt && r_byte != 8'd0) begin
                        n_o_sv   = 1'b1;
                        n_o_slot = b_ws;
                        n_o_off  = b_fl[OW-1:0];
                        n_o_data = r_byte;
                        n_ws     = b_ws;
                        n_fl     = b_fl_inc;
                        n_sw     = 1'b0;
                        n_phase  = scan.phase;
                        n_left   = scan.left;
                        n_idle   = '0;
                        n_seen   = 1'b1;
                        if (scan.close_req && next_slot(b_ws) != r_rd) begin
                            n_pend     = r_pend + PW'(1);
                            n_sw       = 1'b1;
                            n_o_closed = 1'b1;
                        end
                        if (b_fl_inc == FW'(SLOT_BYTES)) begin
                            // slot full: clear everything and halt
                            n_halt     = 1'b1;
                            n_ws       = '0;
                            n_rd       = '0;
                            n_pend     = '0;
                            n_sw       = 1'b0;
                            n_fl       = '0;
                            n_phase    = ipdf_pkg::PH_IDLE;
                            n_left     = '0;
                            n_idle     = '0;
                            n_seen     = 1'b0;
                            n_o_ovf    = 1'b1;
                            n_o_closed = 1'b0;
                        end
                    end
                end
                ipdf_pkg::FN_TICK: begin
                    if (r_seen && r_idle != 8'hFF) begin
                        n_idle = idle_inc;
                        if (idle_inc == r_idle_ticks && r_fl != '0) begin
                            n_phase = ipdf_pkg::PH_IDLE;
                            n_left  = '0;
                            if (!r_sw && next_slot(r_ws) != r_rd) begin
                                n_pend     = r_pend + PW'(1);
                                n_sw       = 1'b1;
                                n_o_closed = 1'b1;
                            end
                        end
                    end
                end
                ipdf_pkg::FN_RELEASE: begin
                    if (r_pend != '0) begin
                        n_rd   = next_slot(r_rd);
                        n_pend = r_pend - PW'(1);
                    end
                end
                ipdf_pkg::FN_RESTART: begin
                    if (r_halt) begin
                        n_halt  = 1'b0;
                        n_ws    = '0;
                        n_rd    = '0;
                        n_pend  = '0;
                        n_sw    = 1'b0;
                        n_fl    = '0;
                        n_phase = ipdf_pkg::PH_IDLE;
                        n_left  = '0;
                        n_idle  = '0;
                        n_seen  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv         <= 1'b0;
            r_ov         <= 1'b0;
            r_idle_ticks <= 8'd10;
            r_halt       <= 1'b0;
            r_ws         <= '0;
            r_rd         <= '0;
            r_pend       <= '0;
            r_sw         <= 1'b0;
            r_fl         <= '0;
            r_phase      <= ipdf_pkg::PH_IDLE;
            r_left       <= '0;
            r_idle       <= '0;
            r_seen       <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_iv <= 1'b1;
            end else if (adv) begin
                r_iv <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_idle_ticks <= i_cfg_wdata;
            end
            r_halt  <= n_halt;
            r_ws    <= n_ws;
            r_rd    <= n_rd;
            r_pend  <= n_pend;
            r_sw    <= n_sw;
            r_fl    <= n_fl;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_idle  <= n_idle;
            r_seen  <= n_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func <= ipdf_pkg::t_func'(i_func);
            r_byte <= i_rx_byte;
        end
        if (adv) begin
            r_o_sv     <= n_o_sv;
            r_o_slot   <= n_o_slot;
            r_o_off    <= n_o_off;
            r_o_data   <= n_o_data;
            r_o_closed <= n_o_closed;
            r_o_ovf    <= n_o_ovf;
            r_o_pend   <= n_pend;
            r_o_rd     <= n_rd;
            r_o_halt   <= n_halt;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_store_valid    = r_o_sv;
    assign o_store_slot     = r_o_slot;
    assign o_store_offset   = r_o_off;
    assign o_store_data     = r_o_data;
    assign o_message_closed = r_o_closed;
    assign o_overflow_error = r_o_ovf;
    assign o_pending_count  = r_o_pend;
    assign o_read_slot      = r_o_rd;
    assign o_halted         = r_o_halt;

    `IPDF_ASSERT(a_ovf_halts, i_clk, i_rst_n, (r_ov && r_o_ovf) |-> o_halted, "overflow without halt")
    `IPDF_ASSERT_NEVER(a_close_ovf, i_clk, i_rst_n, r_ov && r_o_closed && r_o_ovf, "close with overflow")
    `IPDF_ASSERT_NEVER(a_pend_range, i_clk, i_rst_n, r_pend > PW'(SLOTS - 1), "pending past ring size")
    `IPDF_ASSERT(a_close_switch, i_clk, i_rst_n, (adv && n_o_closed) |=> r_sw, "close without slot switch")

endmodule
